>>> hw/rtl/sfe_pkg.sv
// Shared package for the stack frame engine: widths, request codes, micro-op
// encodings, the control-word type and the microcode ROM with its dispatch.
// No dependencies.
package sfe_pkg;

    // Address width of the byte memory; depth, t_addr and the step constants follow it.
    localparam int ADDR_BITS = 12;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;
    localparam int DATA_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int PTR_W     = 12;
    localparam int FIELD_W   = 12;
    localparam int UPC_W     = 6;
    localparam logic [ADDR_BITS-1:0] ONE_A     = ADDR_BITS'(1);
    localparam logic [ADDR_BITS-1:0] WORD_STEP = ADDR_BITS'(2);

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [UPC_W-1:0]     t_upc;

    // Request codes as carried on the input channel.
    typedef enum logic [3:0] {
        REQ_PUSH8   = 4'd0,
        REQ_PUSH16  = 4'd1,
        REQ_POP8    = 4'd2,
        REQ_POP16   = 4'd3,
        REQ_RESERVE = 4'd4,
        REQ_RELEASE = 4'd5,
        REQ_ENTER   = 4'd6,
        REQ_LEAVE   = 4'd7,
        REQ_RD8     = 4'd8,
        REQ_RD16    = 4'd9,
        REQ_WR8     = 4'd10,
        REQ_WR16    = 4'd11,
        REQ_INC8    = 4'd12,
        REQ_INC16   = 4'd13,
        REQ_DEC8    = 4'd14,
        REQ_DEC16   = 4'd15
    } t_req;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_RUN  = 1'b1
    } t_seq_state;

    // Micro-op fields of one control word.
    typedef enum logic [2:0] {
        SP_HOLD, SP_DEC1, SP_DEC2, SP_INC1, SP_INC2, SP_SUBV, SP_ADDV, SP_FROM_FP
    } t_sp_op;

    typedef enum logic [1:0] {
        FP_HOLD, FP_FROM_SP, FP_FROM_DATA
    } t_fp_op;

    typedef enum logic [2:0] {
        ADR_HOLD, ADR_SP, ADR_SPM1, ADR_SPM2, ADR_INC, ADR_FRAME
    } t_adr_op;

    typedef enum logic [1:0] {
        MEM_NONE, MEM_RD, MEM_WR_HI, MEM_WR_LO
    } t_mem_op;

    typedef enum logic [3:0] {
        DAT_HOLD, DAT_VAL, DAT_VAL8, DAT_FP, DAT_SP,
        DAT_LD8, DAT_LD_HI, DAT_LD_LO, DAT_ADJ8, DAT_ADJ16
    } t_dat_op;

    typedef enum logic [1:0] {
        BR_NEXT, BR_GOTO, BR_WORD
    } t_br;

    typedef struct packed {
        t_sp_op  sp;
        t_fp_op  fp;
        t_adr_op adr;
        t_mem_op mem;
        t_dat_op dat;
        t_br     br;
        logic    done;
        t_upc    target;
    } t_uword;

    // Microcode addresses: shared tails first, then the request entries; the four adjust requests share one.
    localparam t_upc UA_RD8_TAIL  = 6'd0;
    localparam t_upc UA_RDW_TAIL  = 6'd2;
    localparam t_upc UA_WRW_TAIL  = 6'd5;
    localparam t_upc UA_WRB_TAIL  = 6'd6;
    localparam t_upc UA_PUSH8     = 6'd7;
    localparam t_upc UA_PUSH16    = 6'd8;
    localparam t_upc UA_POP8      = 6'd9;
    localparam t_upc UA_POP16     = 6'd10;
    localparam t_upc UA_RESERVE   = 6'd11;
    localparam t_upc UA_SP_RESULT = 6'd12;
    localparam t_upc UA_RELEASE   = 6'd13;
    localparam t_upc UA_ENTER     = 6'd14;
    localparam t_upc UA_LEAVE     = 6'd18;
    localparam t_upc UA_RD8       = 6'd24;
    localparam t_upc UA_RD16      = 6'd25;
    localparam t_upc UA_WR8       = 6'd26;
    localparam t_upc UA_WR16      = 6'd27;
    localparam t_upc UA_ADJ       = 6'd28;
    localparam t_upc UA_ADJ_BYTE  = 6'd30;
    localparam t_upc UA_ADJ_WORD  = 6'd32;

    localparam t_uword UW_NOP = '{SP_HOLD, FP_HOLD, ADR_HOLD, MEM_NONE, DAT_HOLD,
                                  BR_NEXT, 1'b0, '0};

    function automatic t_uword mk(t_sp_op sp, t_fp_op fp, t_adr_op adr, t_mem_op mem,
                                  t_dat_op dat, t_br br, logic done, t_upc target);
        t_uword w;
        w.sp     = sp;
        w.fp     = fp;
        w.adr    = adr;
        w.mem    = mem;
        w.dat    = dat;
        w.br     = br;
        w.done   = done;
        w.target = target;
        return w;
    endfunction

    // Entry point of the program for each request.
    function automatic t_upc dispatch(t_req req);
        t_upc a;
        case (req)
            REQ_PUSH8:   a = UA_PUSH8;
            REQ_PUSH16:  a = UA_PUSH16;
            REQ_POP8:    a = UA_POP8;
            REQ_POP16:   a = UA_POP16;
            REQ_RESERVE: a = UA_RESERVE;
            REQ_RELEASE: a = UA_RELEASE;
            REQ_ENTER:   a = UA_ENTER;
            REQ_LEAVE:   a = UA_LEAVE;
            REQ_RD8:     a = UA_RD8;
            REQ_RD16:    a = UA_RD16;
            REQ_WR8:     a = UA_WR8;
            REQ_WR16:    a = UA_WR16;
            default:     a = UA_ADJ;
        endcase
        return a;
    endfunction

    // The microprogram. A memory read issued in one step delivers its byte
    // to the step that runs in the following cycle.
    function automatic t_uword ucode(t_upc upc);
        t_uword w;
        case (upc)
            // Byte read tail.
            6'd0:  w = mk(SP_HOLD, FP_HOLD, ADR_HOLD, MEM_RD, DAT_HOLD, BR_NEXT, 1'b0, '0);
            6'd1:  w = mk(SP_HOLD, FP_HOLD, ADR_HOLD, MEM_NONE, DAT_LD8, BR_NEXT, 1'b1, '0);
            // Word read tail: high byte at the address, low byte after it.
            6'd2:  w = mk(SP_HOLD, FP_HOLD, ADR_INC, MEM_RD, DAT_HOLD, BR_NEXT, 1'b0, '0);
            6'd3:  w = mk(SP_HOLD, FP_HOLD, ADR_HOLD, MEM_RD, DAT_LD_HI, BR_NEXT, 1'b0, '0);
            6'd4:  w = mk(SP_HOLD, FP_HOLD, ADR_HOLD, MEM_NONE, DAT_LD_LO, BR_NEXT, 1'b1, '0);
            // Word write tail, whose last step is also the byte write tail.
            6'd5:  w = mk(SP_HOLD, FP_HOLD, ADR_INC, MEM_WR_HI, DAT_HOLD, BR_NEXT, 1'b0, '0);
            6'd6:  w = mk(SP_HOLD, FP_HOLD, ADR_HOLD, MEM_WR_LO, DAT_HOLD, BR_NEXT, 1'b1, '0);
            // Push and pop.
            6'd7:  w = mk(SP_DEC1, FP_HOLD, ADR_SPM1, MEM_NONE, DAT_VAL8, BR_GOTO, 1'b0,
                          UA_WRB_TAIL);
            6'd8:  w = mk(SP_DEC2, FP_HOLD, ADR_SPM2, MEM_NONE, DAT_VAL, BR_GOTO, 1'b0,
                          UA_WRW_TAIL);
            6'd9:  w = mk(SP_INC1, FP_HOLD, ADR_SP, MEM_NONE, DAT_HOLD, BR_GOTO, 1'b0,
                          UA_RD8_TAIL);
            6'd10: w = mk(SP_INC2, FP_HOLD, ADR_SP, MEM_NONE, DAT_HOLD, BR_GOTO, 1'b0,
                          UA_RDW_TAIL);
            // Reserve and release report the new stack pointer.
            6'd11: w = mk(SP_SUBV, FP_HOLD, ADR_HOLD, MEM_NONE, DAT_HOLD, BR_NEXT, 1'b0, '0);
            6'd12: w = mk(SP_HOLD, FP_HOLD, ADR_HOLD, MEM_NONE, DAT_SP, BR_NEXT, 1'b1, '0);
            6'd13: w = mk(SP_ADDV, FP_HOLD, ADR_HOLD, MEM_NONE, DAT_HOLD, BR_GOTO, 1'b0,
                          UA_SP_RESULT);
            // Enter: push the frame pointer, take the stack pointer, reserve.
            6'd14: w = mk(SP_DEC2, FP_HOLD, ADR_SPM2, MEM_NONE, DAT_FP, BR_NEXT, 1'b0, '0);
            6'd15: w = mk(SP_HOLD, FP_HOLD, ADR_INC, MEM_WR_HI, DAT_HOLD, BR_NEXT, 1'b0, '0);
            6'd16: w = mk(SP_HOLD, FP_FROM_SP, ADR_HOLD, MEM_WR_LO, DAT_HOLD, BR_NEXT, 1'b0,
                          '0);
            6'd17: w = mk(SP_SUBV, FP_HOLD, ADR_HOLD, MEM_NONE, DAT_HOLD, BR_NEXT, 1'b1, '0);
            // Leave: drop to the frame, pop the saved frame pointer.
            6'd18: w = mk(SP_FROM_FP, FP_HOLD, ADR_HOLD, MEM_NONE, DAT_HOLD, BR_NEXT, 1'b0,
                          '0);
            6'd19: w = mk(SP_INC2, FP_HOLD, ADR_SP, MEM_NONE, DAT_HOLD, BR_NEXT, 1'b0, '0);
            6'd20: w = mk(SP_HOLD, FP_HOLD, ADR_INC, MEM_RD, DAT_HOLD, BR_NEXT, 1'b0, '0);
            6'd21: w = mk(SP_HOLD, FP_HOLD, ADR_HOLD, MEM_RD, DAT_LD_HI, BR_NEXT, 1'b0, '0);
            6'd22: w = mk(SP_HOLD, FP_HOLD, ADR_HOLD, MEM_NONE, DAT_LD_LO, BR_NEXT, 1'b0, '0);
            6'd23: w = mk(SP_HOLD, FP_FROM_DATA, ADR_HOLD, MEM_NONE, DAT_HOLD, BR_NEXT, 1'b1,
                          '0);
            // Frame-relative read and write.
            6'd24: w = mk(SP_HOLD, FP_HOLD, ADR_FRAME, MEM_NONE, DAT_HOLD, BR_GOTO, 1'b0,
                          UA_RD8_TAIL);
            6'd25: w = mk(SP_HOLD, FP_HOLD, ADR_FRAME, MEM_NONE, DAT_HOLD, BR_GOTO, 1'b0,
                          UA_RDW_TAIL);
            6'd26: w = mk(SP_HOLD, FP_HOLD, ADR_FRAME, MEM_NONE, DAT_VAL8, BR_GOTO, 1'b0,
                          UA_WRB_TAIL);
            6'd27: w = mk(SP_HOLD, FP_HOLD, ADR_FRAME, MEM_NONE, DAT_VAL, BR_GOTO, 1'b0,
                          UA_WRW_TAIL);
            // Increment and decrement: read, adjust, write back.
            6'd28: w = mk(SP_HOLD, FP_HOLD, ADR_FRAME, MEM_NONE, DAT_HOLD, BR_NEXT, 1'b0, '0);
            6'd29: w = mk(SP_HOLD, FP_HOLD, ADR_INC, MEM_RD, DAT_HOLD, BR_WORD, 1'b0,
                          UA_ADJ_WORD);
            6'd30: w = mk(SP_HOLD, FP_HOLD, ADR_FRAME, MEM_NONE, DAT_LD8, BR_NEXT, 1'b0, '0);
            6'd31: w = mk(SP_HOLD, FP_HOLD, ADR_HOLD, MEM_NONE, DAT_ADJ8, BR_GOTO, 1'b0,
                          UA_WRB_TAIL);
            6'd32: w = mk(SP_HOLD, FP_HOLD, ADR_HOLD, MEM_RD, DAT_LD_HI, BR_NEXT, 1'b0, '0);
            6'd33: w = mk(SP_HOLD, FP_HOLD, ADR_HOLD, MEM_NONE, DAT_LD_LO, BR_NEXT, 1'b0, '0);
            6'd34: w = mk(SP_HOLD, FP_HOLD, ADR_FRAME, MEM_NONE, DAT_ADJ16, BR_GOTO, 1'b0,
                          UA_WRW_TAIL);
            default: w = mk(SP_HOLD, FP_HOLD, ADR_HOLD, MEM_NONE, DAT_HOLD, BR_NEXT, 1'b1,
                            '0);
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/stack_frame_engine.sv
// Top level of the stack frame engine: pointer and data registers driven by
// the microcode sequencer, the byte stack memory and the result register.
// Depends on sfe_pkg, sfe_ram and sfe_seq.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------------
//   request | in        | i_in_valid / o_in_ready  | i_req_type i_offset i_index i_value
//   result  | out       | o_out_valid / i_out_ready| o_data_out o_stack_ptr o_frame_ptr
//   config  | in        | i_cfg_we                 | i_cfg_data (stack top)
//
// An item is taken in while idle and then runs its microprogram: 2 steps for
// push8, wr8, reserve and release; 3 for push16, pop8, rd8 and wr16; 4 for
// pop16, rd16 and enter; 6 for leave; 5 for inc8/dec8 and 7 for inc16/dec16.
// The step count is set by the single byte port of the memory: one byte per
// step, read data arriving a step later. One item is in work at a time; the
// result register lets the next item be taken while a result waits. A full
// result register stalls only the last step of the next program. Reset loads
// both pointers with zero; the memory is not cleared.
module stack_frame_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [3:0]                  i_req_type,
    input  logic [sfe_pkg::FIELD_W-1:0] i_offset,
    input  logic [sfe_pkg::FIELD_W-1:0] i_index,
    input  logic [sfe_pkg::DATA_W-1:0]  i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [sfe_pkg::DATA_W-1:0]  o_data_out,
    output logic [sfe_pkg::PTR_W-1:0]   o_stack_ptr,
    output logic [sfe_pkg::PTR_W-1:0]   o_frame_ptr,
    input  logic                        i_cfg_we,
    input  logic [sfe_pkg::PTR_W-1:0]   i_cfg_data
);

    sfe_pkg::t_addr              r_sp, n_sp;
    sfe_pkg::t_addr              r_fp, n_fp;
    sfe_pkg::t_addr              r_addr, n_addr;
    logic [sfe_pkg::DATA_W-1:0]  r_data, n_data;
    sfe_pkg::t_req               r_req;
    logic [sfe_pkg::FIELD_W-1:0] r_off;
    logic [sfe_pkg::FIELD_W-1:0] r_idx;
    logic [sfe_pkg::DATA_W-1:0]  r_val;
    logic                        r_out_valid;
    logic [sfe_pkg::DATA_W-1:0]  r_out_data;
    logic [sfe_pkg::PTR_W-1:0]   r_out_sp;
    logic [sfe_pkg::PTR_W-1:0]   r_out_fp;

    sfe_pkg::t_uword             uw;
    logic                        busy;
    logic                        accept;
    logic                        go;
    logic                        word;
    logic                        dec;
    sfe_pkg::t_addr              frame_addr;
    sfe_pkg::t_addr              count;
    logic                        ram_we;
    logic                        ram_re;
    logic [sfe_pkg::BYTE_W-1:0]  ram_wdata;
    logic [sfe_pkg::BYTE_W-1:0]  ram_rdata;

    assign o_in_ready = !busy;
    assign accept     = i_in_valid && o_in_ready;
    // The final step waits while an earlier result is still held.
    assign go         = !uw.done || !r_out_valid || i_out_ready;
    assign word       = r_req[0];
    assign dec        = r_req[1];
    assign count      = sfe_pkg::ADDR_BITS'(r_val);

    // Frame address: frame pointer less offset plus index, the index doubled for words.
    always_comb begin
        if (word) begin
            frame_addr = r_fp - sfe_pkg::ADDR_BITS'(r_off)
                       + sfe_pkg::ADDR_BITS'({r_idx, 1'b0});
        end else begin
            frame_addr = r_fp - sfe_pkg::ADDR_BITS'(r_off) + sfe_pkg::ADDR_BITS'(r_idx);
        end
    end

    sfe_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_req   (sfe_pkg::t_req'(i_req_type)),
        .i_word  (word),
        .i_go    (go),
        .o_busy  (busy),
        .o_uw    (uw)
    );

    // Stack pointer update.
    always_comb begin
        case (uw.sp)
            sfe_pkg::SP_DEC1:    n_sp = r_sp - sfe_pkg::ONE_A;
            sfe_pkg::SP_DEC2:    n_sp = r_sp - sfe_pkg::WORD_STEP;
            sfe_pkg::SP_INC1:    n_sp = r_sp + sfe_pkg::ONE_A;
            sfe_pkg::SP_INC2:    n_sp = r_sp + sfe_pkg::WORD_STEP;
            sfe_pkg::SP_SUBV:    n_sp = r_sp - count;
            sfe_pkg::SP_ADDV:    n_sp = r_sp + count;
            sfe_pkg::SP_FROM_FP: n_sp = r_fp;
            default:             n_sp = r_sp;
        endcase
    end

    // Frame pointer update.
    always_comb begin
        case (uw.fp)
            sfe_pkg::FP_FROM_SP:   n_fp = r_sp;
            sfe_pkg::FP_FROM_DATA: n_fp = sfe_pkg::ADDR_BITS'(r_data);
            default:               n_fp = r_fp;
        endcase
    end

    // Memory address register.
    always_comb begin
        case (uw.adr)
            sfe_pkg::ADR_SP:    n_addr = r_sp;
            sfe_pkg::ADR_SPM1:  n_addr = r_sp - sfe_pkg::ONE_A;
            sfe_pkg::ADR_SPM2:  n_addr = r_sp - sfe_pkg::WORD_STEP;
            sfe_pkg::ADR_INC:   n_addr = r_addr + sfe_pkg::ONE_A;
            sfe_pkg::ADR_FRAME: n_addr = frame_addr;
            default:            n_addr = r_addr;
        endcase
    end

    // Data register: loads, byte assembly and increment or decrement.
    always_comb begin
        case (uw.dat)
            sfe_pkg::DAT_VAL:   n_data = r_val;
            sfe_pkg::DAT_VAL8:  n_data = {8'h00, r_val[7:0]};
            sfe_pkg::DAT_FP:    n_data = sfe_pkg::DATA_W'(r_fp);
            sfe_pkg::DAT_SP:    n_data = sfe_pkg::DATA_W'(r_sp);
            sfe_pkg::DAT_LD8:   n_data = {8'h00, ram_rdata};
            sfe_pkg::DAT_LD_HI: n_data = {ram_rdata, 8'h00};
            sfe_pkg::DAT_LD_LO: n_data = {r_data[15:8], ram_rdata};
            sfe_pkg::DAT_ADJ8:  n_data = {8'h00, dec ? r_data[7:0] - 8'd1
                                                     : r_data[7:0] + 8'd1};
            sfe_pkg::DAT_ADJ16: n_data = dec ? r_data - 16'd1 : r_data + 16'd1;
            default:            n_data = r_data;
        endcase
    end

    // Memory port controls.
    assign ram_re    = go && (uw.mem == sfe_pkg::MEM_RD);
    assign ram_we    = go && (uw.mem == sfe_pkg::MEM_WR_HI || uw.mem == sfe_pkg::MEM_WR_LO);
    assign ram_wdata = (uw.mem == sfe_pkg::MEM_WR_HI) ? r_data[15:8] : r_data[7:0];

    sfe_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (r_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Pointers: reset and configuration load both; steps update them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
            r_fp <= '0;
        end else if (i_cfg_we) begin
            r_sp <= sfe_pkg::ADDR_BITS'(i_cfg_data);
            r_fp <= sfe_pkg::ADDR_BITS'(i_cfg_data);
        end else if (go) begin
            r_sp <= n_sp;
            r_fp <= n_fp;
        end
    end

    // Working registers and the captured request fields.
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_addr <= n_addr;
            r_data <= n_data;
        end
        if (accept) begin
            r_req <= sfe_pkg::t_req'(i_req_type);
            r_off <= i_offset;
            r_idx <= i_index;
            r_val <= i_value;
        end
    end

    // Result register: loaded by the final step of a program.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uw.done && go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.done && go) begin
            r_out_data <= n_data;
            r_out_sp   <= sfe_pkg::PTR_W'(n_sp);
            r_out_fp   <= sfe_pkg::PTR_W'(n_fp);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_stack_ptr = r_out_sp;
    assign o_frame_ptr = r_out_fp;

    // An accepted item always starts a program, so the port closes at once.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("request taken but sequencer not running");

    // The memory is only written by a running program.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> busy)
        else $error("memory write outside a program");

    // Pointers hold while idle unless reloaded by configuration.
    a_idle_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !i_cfg_we) |=> ($stable(r_sp) && $stable(r_fp)))
        else $error("pointer changed while idle");

    // A finished step never overwrites a result that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.done && r_out_valid && !i_out_ready) |=> $stable(r_out_data))
        else $error("waiting result overwritten");

endmodule

>>> hw/rtl/sfe_ram.sv
// Byte-wide single-port stack memory with registered read data.
// Depends on sfe_pkg for the address width and depth.
module sfe_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic                       i_re,
    input  sfe_pkg::t_addr             i_addr,
    input  logic [sfe_pkg::BYTE_W-1:0] i_wdata,
    output logic [sfe_pkg::BYTE_W-1:0] o_rdata
);

    logic [sfe_pkg::BYTE_W-1:0] r_mem [sfe_pkg::MEM_DEPTH];
    logic [sfe_pkg::BYTE_W-1:0] r_rdata;

    // One address serves write and read; the read byte is held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/sfe_seq.sv
// Microcode sequencer: step counter, dispatch and branch logic over the
// control ROM. Depends on sfe_pkg for the ROM, dispatch table and types.
module sfe_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  sfe_pkg::t_req   i_req,
    input  logic            i_word,
    input  logic            i_go,
    output logic            o_busy,
    output sfe_pkg::t_uword o_uw
);

    sfe_pkg::t_seq_state r_state, n_state;
    sfe_pkg::t_upc       r_upc, n_upc;
    sfe_pkg::t_uword     rom_w;

    assign rom_w = sfe_pkg::ucode(r_upc);

    // Next state and step counter.
    always_comb begin
        n_state = r_state;
        n_upc   = r_upc;
        case (r_state)
            sfe_pkg::SEQ_IDLE: begin
                if (i_start) begin
                    n_state = sfe_pkg::SEQ_RUN;
                    n_upc   = sfe_pkg::dispatch(i_req);
                end
            end
            sfe_pkg::SEQ_RUN: begin
                if (i_go) begin
                    if (rom_w.done) begin
                        n_state = sfe_pkg::SEQ_IDLE;
                    end else if (rom_w.br == sfe_pkg::BR_GOTO ||
                                 (rom_w.br == sfe_pkg::BR_WORD && i_word)) begin
                        n_upc = rom_w.target;
                    end else begin
                        n_upc = r_upc + 1'b1;
                    end
                end
            end
            default: begin
                n_state = sfe_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Outputs: the control word only takes effect while a program runs.
    always_comb begin
        case (r_state)
            sfe_pkg::SEQ_RUN: begin
                o_busy = 1'b1;
                o_uw   = rom_w;
            end
            default: begin
                o_busy = 1'b0;
                o_uw   = sfe_pkg::UW_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfe_pkg::SEQ_IDLE;
            r_upc   <= '0;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
        end
    end

endmodule
